// ===== rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes of the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned SetupW = 8;
  localparam int unsigned HalfW  = 10;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_STOP  = 3'd4;

  localparam logic CFG_SETUP = 1'b0;
  localparam logic CFG_HALF  = 1'b1;

  typedef struct packed {
    logic [2:0] opcode;
    logic [6:0] target_address;
    logic       read_direction;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       scl_in;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic       acked;
    logic [7:0] read_byte;
  } result_t;

endpackage

// ===== rtl/i2cm_in_stage.sv =====
// ----------------------------------------------------------------------------
// i2cm_in_stage
// Input register of the engine: holds one item until the sequencer takes it.
// ----------------------------------------------------------------------------
module i2cm_in_stage import i2cm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  item_t item_i,
  input  logic  take_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  assign in_stall_o = valid_q && !take_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== rtl/i2cm_seq.sv =====
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus sequencer: one tick of the start/bit/stop state machine per item.
// ----------------------------------------------------------------------------
module i2cm_seq import i2cm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  item_t             item_i,
  input  logic [SetupW-1:0] setup_ticks_i,
  input  logic [HalfW-1:0]  half_period_ticks_i,
  output result_t           res_o
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_START_REL, PH_START_SDA, PH_START_SCL,
    PH_W_SETUP, PH_W_HIGH, PH_W_LOW,
    PH_R_SETUP, PH_R_HIGH, PH_R_LOW,
    PH_STOP_LOW, PH_STOP_SCL, PH_STOP_REL
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [3:0]       bit_count_q, bit_count_d;
  logic [7:0]       shift_q, shift_d;
  logic [HalfW-1:0] wait_q, wait_d;
  logic             scl_q, scl_d, sda_q, sda_d;
  logic             ack_level_q, ack_level_d;
  logic [7:0]       captured_q, captured_d;
  logic             ack_seen_q, ack_seen_d;
  logic             done;
  logic [HalfW-1:0] delay;
  logic [3:0]       bit_next;
  logic [7:0]       shift_next;

  always_comb begin
    phase_d     = phase_q;
    bit_count_d = bit_count_q;
    shift_d     = shift_q;
    wait_d      = wait_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    ack_level_d = ack_level_q;
    captured_d  = captured_q;
    ack_seen_d  = ack_seen_q;
    done        = 1'b0;
    bit_next    = bit_count_q + 4'd1;
    shift_next  = {shift_q[6:0], 1'b0};
    if (phase_q == PH_W_SETUP || phase_q == PH_R_SETUP) begin
      delay = {{(HalfW-SetupW){1'b0}}, setup_ticks_i};
    end else begin
      delay = half_period_ticks_i;
    end

    if (phase_q == PH_IDLE) begin
      bit_count_d = 4'd0;
      wait_d      = '0;
      case (item_i.opcode)
        OP_START: begin
          shift_d = {item_i.target_address, item_i.read_direction};
          phase_d = PH_START_REL;
          scl_d   = 1'b1;
          sda_d   = 1'b1;
        end
        OP_WRITE: begin
          shift_d = item_i.data_byte;
          phase_d = PH_W_SETUP;
          scl_d   = 1'b0;
          sda_d   = item_i.data_byte[7];
        end
        OP_READ: begin
          shift_d     = 8'd0;
          ack_level_d = item_i.send_ack;
          phase_d     = PH_R_SETUP;
          scl_d       = 1'b0;
          sda_d       = 1'b1;
        end
        OP_STOP: begin
          phase_d = PH_STOP_LOW;
          scl_d   = 1'b0;
          sda_d   = 1'b0;
        end
        default: begin
          wait_d = wait_q;
        end
      endcase
    end else if (scl_q && !item_i.scl_in) begin
      wait_d = wait_q;
    end else if (wait_q < delay) begin
      wait_d = wait_q + HalfW'(1);
    end else begin
      wait_d = '0;
      case (phase_q)
        PH_START_REL: begin
          if (item_i.scl_in && item_i.sda_in) begin
            phase_d = PH_START_SDA;
            scl_d   = 1'b1;
            sda_d   = 1'b0;
          end else begin
            wait_d = wait_q;
          end
        end
        PH_START_SDA: begin
          phase_d = PH_START_SCL;
          scl_d   = 1'b0;
          sda_d   = 1'b0;
        end
        PH_START_SCL: begin
          bit_count_d = 4'd0;
          phase_d     = PH_W_SETUP;
          scl_d       = 1'b0;
          sda_d       = shift_q[7];
        end
        PH_W_SETUP: begin
          phase_d = PH_W_HIGH;
          scl_d   = 1'b1;
        end
        PH_R_SETUP: begin
          phase_d = PH_R_HIGH;
          scl_d   = 1'b1;
        end
        PH_W_HIGH: begin
          if (bit_count_q[3]) begin
            ack_seen_d = !item_i.sda_in;
          end
          phase_d = PH_W_LOW;
          scl_d   = 1'b0;
        end
        PH_R_HIGH: begin
          if (!bit_count_q[3]) begin
            shift_d = {shift_q[6:0], item_i.sda_in};
          end
          phase_d = PH_R_LOW;
          scl_d   = 1'b0;
        end
        PH_W_LOW: begin
          if (bit_count_q[3]) begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end else begin
            shift_d     = shift_next;
            bit_count_d = bit_next;
            phase_d     = PH_W_SETUP;
            scl_d       = 1'b0;
            sda_d       = bit_next[3] ? 1'b1 : shift_next[7];
          end
        end
        PH_R_LOW: begin
          if (bit_count_q[3]) begin
            captured_d = shift_q;
            phase_d    = PH_IDLE;
            done       = 1'b1;
          end else begin
            bit_count_d = bit_next;
            phase_d     = PH_R_SETUP;
            scl_d       = 1'b0;
            sda_d       = bit_next[3] ? !ack_level_q : 1'b1;
          end
        end
        PH_STOP_LOW: begin
          phase_d = PH_STOP_SCL;
          scl_d   = 1'b1;
          sda_d   = 1'b0;
        end
        PH_STOP_SCL: begin
          phase_d = PH_STOP_REL;
          scl_d   = 1'b1;
          sda_d   = 1'b1;
        end
        PH_STOP_REL: begin
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  assign res_o.scl_release = scl_d;
  assign res_o.sda_release = sda_d;
  assign res_o.busy_res    = (phase_d != PH_IDLE);
  assign res_o.done_res    = done;
  assign res_o.acked       = ack_seen_d;
  assign res_o.read_byte   = captured_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_count_q <= 4'd0;
      shift_q     <= 8'd0;
      wait_q      <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      ack_level_q <= 1'b0;
      captured_q  <= 8'd0;
      ack_seen_q  <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      bit_count_q <= bit_count_d;
      shift_q     <= shift_d;
      wait_q      <= wait_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      ack_level_q <= ack_level_d;
      captured_q  <= captured_d;
      ack_seen_q  <= ack_seen_d;
    end
  end

endmodule

// ===== rtl/i2c_master_bit_engine.sv =====
// An accepted item passes from the input register through the sequencer into the output register.
// Throughput: one item per cycle while the result side does not stall.
// The input register takes a new item while a finished result waits, if it holds none.
// Reset: sequencer bus lines released, engine idle, setup 1 tick, half period 5 ticks,
// no item or result held.
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// Single-master I2C bit engine with 7-bit addressing and clock stretching.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine import i2cm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [HalfW-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       opcode_i,
  input  logic [6:0]       target_address_i,
  input  logic             read_direction_i,
  input  logic [7:0]       data_byte_i,
  input  logic             send_ack_i,
  input  logic             scl_in_i,
  input  logic             sda_in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             scl_release_o,
  output logic             sda_release_o,
  output logic             busy_res_o,
  output logic             done_res_o,
  output logic             acked_o,
  output logic [7:0]       read_byte_o
);

  logic [SetupW-1:0] setup_q;
  logic [HalfW-1:0]  half_q;
  item_t             in_item;
  item_t             s1_item;
  logic              s1_valid;
  logic              take;
  result_t           res;
  result_t           out_q;
  logic              out_valid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_q <= SetupW'(1);
      half_q  <= HalfW'(5);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SETUP: setup_q <= cfg_data_i[SetupW-1:0];
        CFG_HALF:  half_q  <= cfg_data_i;
        default:   half_q  <= half_q;
      endcase
    end
  end

  assign in_item.opcode         = opcode_i;
  assign in_item.target_address = target_address_i;
  assign in_item.read_direction = read_direction_i;
  assign in_item.data_byte      = data_byte_i;
  assign in_item.send_ack       = send_ack_i;
  assign in_item.scl_in         = scl_in_i;
  assign in_item.sda_in         = sda_in_i;

  assign take = s1_valid && (!out_valid_q || !out_stall_i);

  i2cm_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .take_i     (take),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  i2cm_seq u_seq (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .step_i              (take),
    .item_i              (s1_item),
    .setup_ticks_i       (setup_q),
    .half_period_ticks_i (half_q),
    .res_o               (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign scl_release_o = out_q.scl_release;
  assign sda_release_o = out_q.sda_release;
  assign busy_res_o    = out_q.busy_res;
  assign done_res_o    = out_q.done_res;
  assign acked_o       = out_q.acked;
  assign read_byte_o   = out_q.read_byte;

endmodule

// ===== rtl/i2cm_checker.sv =====
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks of the I2C master bit engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       scl_release_o,
  input logic       sda_release_o,
  input logic       busy_res_o,
  input logic       done_res_o,
  input logic       acked_o,
  input logic [7:0] read_byte_o
);

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done item shows busy");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while result side free");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(scl_release_o)
      && $stable(sda_release_o) && $stable(busy_res_o) && $stable(done_res_o)
      && $stable(acked_o) && $stable(read_byte_o))
    else $error("stalled result item changed");

  a_item_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o ##1 !out_valid_o |=> out_valid_o)
    else $error("accepted item produced no result");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .scl_release_o (scl_release_o),
  .sda_release_o (sda_release_o),
  .busy_res_o    (busy_res_o),
  .done_res_o    (done_res_o),
  .acked_o       (acked_o),
  .read_byte_o   (read_byte_o)
);
